FILE: sv/mvmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvmc_pkg
// Shared types, constants and the gain table of the volume and mute controller.
// ----------------------------------------------------------------------------
package mvmc_pkg;

  // Channel count and derived widths
  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned CH_IDX_W  = $clog2(CHANNELS);
  localparam int unsigned CH_FLD_W  = 3;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned GAIN_W    = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 7;

  // Level limits and gain saturation
  localparam int unsigned          FULL_LEVEL = 100;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX  = LEVEL_W'(FULL_LEVEL);
  localparam logic [GAIN_W-1:0]    GAIN_MAX   = {GAIN_W{1'b1}};

  // Step register reset values
  localparam logic [LEVEL_W-1:0] BIG_STEP_RST   = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] SMALL_STEP_RST = LEVEL_W'(5);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_STEP = 1'b1;

  // Command kinds
  typedef enum logic [2:0] {
    K_SET        = 3'd0,
    K_BIG_UP     = 3'd1,
    K_SMALL_UP   = 3'd2,
    K_BIG_DOWN   = 3'd3,
    K_SMALL_DOWN = 3'd4,
    K_MUTE_ON    = 3'd5,
    K_MUTE_OFF   = 3'd6,
    K_TOGGLE     = 3'd7
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic                load;   // latch kind and level of an accepted command
    logic                step;   // update one channel and load the output register
    logic                first;  // this step is the first affected channel
    logic                last;   // this step is the final affected channel
    logic [CH_IDX_W-1:0] idx;    // channel being updated
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register empty or being taken this cycle
  } dp_status_t;

  // Gain table: floor(level * 2^31 / 100), saturated
  localparam int unsigned LUT_DEPTH = 2 ** LEVEL_W;
  typedef logic [GAIN_W-1:0] gain_lut_t [LUT_DEPTH];

  function automatic gain_lut_t build_gain_lut();
    gain_lut_t    lut;
    logic [39:0]  prod;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      prod = (40'(i) << GAIN_W) / 40'(FULL_LEVEL);
      lut[i] = (prod > 40'(GAIN_MAX)) ? GAIN_MAX : prod[GAIN_W-1:0];
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = build_gain_lut();

endpackage
`default_nettype wire

FILE: sv/mvmc_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvmc_cmd_if
// Command channel: kind, channel and level with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mvmc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          kind;
  logic [mvmc_pkg::CH_FLD_W-1:0]       channel;
  logic [mvmc_pkg::LEVEL_W-1:0]        level;

  modport source (output valid, kind, channel, level, input ready);
  modport sink   (input valid, kind, channel, level, output ready);
endinterface

// ----------------------------------------------------------------------------
// mvmc_gain_if
// Result channel: one trim gain command per affected channel.
// ----------------------------------------------------------------------------
interface mvmc_gain_if;
  logic                                valid;
  logic                                ready;
  logic [mvmc_pkg::CH_IDX_W-1:0]       target_channel;
  logic [mvmc_pkg::GAIN_W-1:0]         gain_word;
  logic [mvmc_pkg::LEVEL_W-1:0]        reply_value;
  logic                                last;

  modport source (output valid, target_channel, gain_word, reply_value, last, input ready);
  modport sink   (input valid, target_channel, gain_word, reply_value, last, output ready);
endinterface
`default_nettype wire

FILE: sv/multichannel_volume_mute_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_volume_mute_controller
// Volume and mute control for four channels with one gain transfer per channel.
// ----------------------------------------------------------------------------
// A command is taken while the sequencer is idle and then produces one gain
// transfer per affected channel, one per cycle while the output register can
// take it: a single-channel command affects one channel, a broadcast (channel
// zero) all four. The sequencer updates one channel's level and mute flag per
// cycle through a single update unit and the output register, and holds while
// the output side stalls. A new command is taken as soon as the sequencer is
// idle, even while the final transfer of the previous one still waits in the
// output register. Commands to a channel above four are taken and dropped.
// ----------------------------------------------------------------------------
module multichannel_volume_mute_controller (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mvmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mvmc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  mvmc_cmd_if.sink                            cmd_in,
  mvmc_gain_if.source                         gain_out
);
  import mvmc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer
  mvmc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_in.valid),
    .in_channel_i (cmd_in.channel),
    .in_ready_o   (cmd_in.ready),
    .status_i     (dp_status),
    .cmd_o        (dp_cmd)
  );

  // Datapath
  mvmc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_kind_i     (cmd_in.kind),
    .in_level_i    (cmd_in.level),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .out_valid_o   (gain_out.valid),
    .out_ready_i   (gain_out.ready),
    .out_channel_o (gain_out.target_channel),
    .out_gain_o    (gain_out.gain_word),
    .out_reply_o   (gain_out.reply_value),
    .out_last_o    (gain_out.last)
  );

  // A channel update never overwrites a transfer still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.step |-> (!gain_out.valid || gain_out.ready))
    else $error("channel update while output register is blocked");

  // The final channel update returns the sequencer to accepting commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.step && dp_cmd.last) |=> cmd_in.ready)
    else $error("sequencer not idle after final channel");

  // An accepted command in range blocks further commands in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_in.valid && cmd_in.ready && cmd_in.channel <= CH_FLD_W'(CHANNELS))
      |=> !cmd_in.ready)
    else $error("command accepted while previous still in progress");

  // Every channel update yields a valid transfer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.step |=> gain_out.valid)
    else $error("channel update did not load the output register");

endmodule
`default_nettype wire

FILE: sv/mvmc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvmc_ctrl
// Sequencer: takes a command, walks its channels one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mvmc_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [mvmc_pkg::CH_FLD_W-1:0] in_channel_i,
  output logic                               in_ready_o,
  input  wire mvmc_pkg::dp_status_t          status_i,
  output mvmc_pkg::dp_cmd_t                  cmd_o
);
  import mvmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CH_IDX_W-1:0] idx_q, idx_d;
  logic [CH_IDX_W-1:0] last_q, last_d;
  logic                first_q, first_d;
  logic                in_range;

  assign in_range = (in_channel_i <= CH_FLD_W'(CHANNELS));

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    last_d     = last_q;
    first_d    = first_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        // drop commands to channels that do not exist
        if (in_valid_i && in_range) begin
          cmd_o.load = 1'b1;
          first_d    = 1'b1;
          state_d    = S_RUN;
          if (in_channel_i == '0) begin
            idx_d  = '0;
            last_d = CH_IDX_W'(CHANNELS - 1);
          end else begin
            idx_d  = CH_IDX_W'(in_channel_i - 1'b1);
            last_d = CH_IDX_W'(in_channel_i - 1'b1);
          end
        end
      end
      S_RUN: begin
        // advance one channel whenever the output register can take it
        if (status_i.slot_free) begin
          cmd_o.step  = 1'b1;
          cmd_o.first = first_q;
          cmd_o.last  = (idx_q == last_q);
          first_d     = 1'b0;
          if (idx_q == last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      last_q  <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mvmc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvmc_datapath
// Channel state, step registers, level update and the output register.
// ----------------------------------------------------------------------------
module mvmc_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mvmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mvmc_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  wire logic [2:0]                      in_kind_i,
  input  wire logic [mvmc_pkg::LEVEL_W-1:0]    in_level_i,
  input  wire mvmc_pkg::dp_cmd_t               cmd_i,
  output mvmc_pkg::dp_status_t                 status_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [mvmc_pkg::CH_IDX_W-1:0]        out_channel_o,
  output logic [mvmc_pkg::GAIN_W-1:0]          out_gain_o,
  output logic [mvmc_pkg::LEVEL_W-1:0]         out_reply_o,
  output logic                                 out_last_o
);
  import mvmc_pkg::*;

  logic [LEVEL_W-1:0]  big_step_q, small_step_q;
  kind_e               kind_q;
  logic [LEVEL_W-1:0]  set_level_q;
  logic [LEVEL_W-1:0]  level_q [CHANNELS];
  logic                muted_q [CHANNELS];

  logic                out_valid_q;
  logic [CH_IDX_W-1:0] out_channel_q;
  logic [GAIN_W-1:0]   out_gain_q;
  logic [LEVEL_W-1:0]  out_reply_q;
  logic                out_last_q;

  logic [LEVEL_W-1:0]  cur_level, new_level, step_raw, step_c, reply;
  logic [LEVEL_W:0]    sum;
  logic                cur_muted, new_muted;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_step_q   <= BIG_STEP_RST;
      small_step_q <= SMALL_STEP_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BIG_STEP)   big_step_q   <= cfg_data_i;
      if (cfg_idx_i == CFG_SMALL_STEP) small_step_q <= cfg_data_i;
    end
  end

  // Hold the accepted command, set level clamped to full scale
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= kind_e'(in_kind_i);
      set_level_q <= (in_level_i > LEVEL_MAX) ? LEVEL_MAX : in_level_i;
    end
  end

  // Per-channel update
  assign cur_level = level_q[cmd_i.idx];
  assign cur_muted = muted_q[cmd_i.idx];
  assign step_raw  = (kind_q == K_BIG_UP || kind_q == K_BIG_DOWN) ? big_step_q : small_step_q;
  assign step_c    = (step_raw > LEVEL_MAX) ? LEVEL_MAX : step_raw;
  assign sum       = {1'b0, cur_level} + {1'b0, step_c};

  always_comb begin
    new_level = cur_level;
    new_muted = 1'b0;
    reply     = '0;
    unique case (kind_q)
      K_SET: begin
        new_level = set_level_q;
        reply     = new_level;
      end
      K_BIG_UP, K_SMALL_UP: begin
        new_level = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
        reply     = new_level;
      end
      K_BIG_DOWN, K_SMALL_DOWN: begin
        new_level = (cur_level > step_c) ? (cur_level - step_c) : '0;
        reply     = new_level;
      end
      K_MUTE_ON: begin
        new_muted = 1'b1;
      end
      K_MUTE_OFF: begin
        new_muted = 1'b0;
      end
      K_TOGGLE: begin
        new_muted = ~cur_muted;
        reply     = LEVEL_W'(new_muted);
      end
      default: begin
        new_muted = cur_muted;
      end
    endcase
  end

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i] <= '0;
        muted_q[i] <= 1'b0;
      end
    end else if (cmd_i.step) begin
      level_q[cmd_i.idx] <= new_level;
      muted_q[cmd_i.idx] <= new_muted;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; reply comes from the first channel and holds after
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_channel_q <= cmd_i.idx;
      out_gain_q    <= new_muted ? '0 : GAIN_LUT[new_level];
      out_last_q    <= cmd_i.last;
      if (cmd_i.first) out_reply_q <= reply;
    end
  end

  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_channel_o      = out_channel_q;
  assign out_gain_o         = out_gain_q;
  assign out_reply_o        = out_reply_q;
  assign out_last_o         = out_last_q;

endmodule
`default_nettype wire
